>>> rtl/rcfd_pkg.sv
// ----------------------------------------------------------------------------
// rcfd_pkg
// Shared types and constants of the receiver frame decoder.
// ----------------------------------------------------------------------------
package rcfd_pkg;

    localparam int FRAME_BYTES = 18;
    localparam int BUF_BYTES   = FRAME_BYTES - 1;
    localparam int POS_W       = 5;
    localparam int QUEUE_DEPTH = 2;

    localparam int CH_W    = 11;
    localparam int STICK_W = 12;
    localparam int WORD_W  = 16;
    localparam int DZ_W    = 8;
    localparam int SW_W    = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [CH_W-1:0] RST_CHANNEL_MIN    = 11'd364;
    localparam logic [CH_W-1:0] RST_CHANNEL_MAX    = 11'd1684;
    localparam logic [CH_W-1:0] RST_CHANNEL_CENTER = 11'd1024;
    localparam logic [DZ_W-1:0] RST_DEAD_ZONE      = 8'd5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHANNEL_MIN    = 2'd0,
        CFG_CHANNEL_MAX    = 2'd1,
        CFG_CHANNEL_CENTER = 2'd2,
        CFG_DEAD_ZONE      = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [CH_W-1:0] channel_min;
        logic [CH_W-1:0] channel_max;
        logic [CH_W-1:0] channel_center;
        logic [DZ_W-1:0] dead_zone;
    } t_cfg;

    // Whole frame, byte 0 in the lowest position.
    typedef logic [FRAME_BYTES-1:0][7:0] t_frame;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Centre a raw channel and force small magnitudes to zero.
    function automatic logic signed [STICK_W-1:0] center_stick(
        input logic [CH_W-1:0] raw,
        input logic [CH_W-1:0] center,
        input logic [DZ_W-1:0] dz
    );
        logic signed [STICK_W:0] v;
        logic signed [STICK_W:0] d;
        v = $signed({2'b00, raw}) - $signed({2'b00, center});
        d = $signed({5'b00000, dz});
        if ((v <= d) && (v >= -d)) begin
            v = '0;
        end
        return v[STICK_W-1:0];
    endfunction

endpackage

>>> rtl/rc_receiver_frame_decoder_core.sv
// ----------------------------------------------------------------------------
// rc_receiver_frame_decoder_core
// Receiver frame decoder: byte assembly, frame queue and decode with held values.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while the frame queue has room; one result for every completed 18-byte frame.
// Each frame is written into the frame queue on its final byte's beat, and is then
// decoded into the decode stage's output register once that register is free.
// Bytes are taken while the two-entry frame queue has room.
// Reset: configuration returns to its defaults, held values clear to zero,
// the byte position returns to zero and the queue empties.
module rc_receiver_frame_decoder_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [7:0]                            i_rx_byte,
    input  logic                                  i_frame_start,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [rcfd_pkg::STICK_W-1:0]   o_stick_right_x,
    output logic signed [rcfd_pkg::STICK_W-1:0]   o_stick_right_y,
    output logic signed [rcfd_pkg::STICK_W-1:0]   o_stick_left_x,
    output logic signed [rcfd_pkg::STICK_W-1:0]   o_stick_left_y,
    output logic signed [rcfd_pkg::WORD_W-1:0]    o_wheel_channel,
    output logic [rcfd_pkg::SW_W-1:0]             o_switch_pair,
    output logic signed [rcfd_pkg::WORD_W-1:0]    o_mouse_x,
    output logic signed [rcfd_pkg::WORD_W-1:0]    o_mouse_y,
    output logic signed [rcfd_pkg::WORD_W-1:0]    o_mouse_z,
    output logic [rcfd_pkg::WORD_W-1:0]           o_mouse_buttons,
    output logic [rcfd_pkg::WORD_W-1:0]           o_key_mask,
    output logic                                  o_frame_accepted,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [rcfd_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [rcfd_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    rcfd_pkg::t_cfg        r_cfg;
    rcfd_pkg::t_frame      w_push_frame;
    rcfd_pkg::t_frame      w_head;
    rcfd_pkg::t_q_status   w_q_status;
    logic                  w_accept;
    logic                  w_push;
    logic                  w_pop;
    logic signed [rcfd_pkg::STICK_W-1:0] w_stick [4];
    logic signed [rcfd_pkg::WORD_W-1:0]  w_mouse [3];

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !w_q_status.full;
    assign w_accept    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.channel_min    <= rcfd_pkg::RST_CHANNEL_MIN;
            r_cfg.channel_max    <= rcfd_pkg::RST_CHANNEL_MAX;
            r_cfg.channel_center <= rcfd_pkg::RST_CHANNEL_CENTER;
            r_cfg.dead_zone      <= rcfd_pkg::RST_DEAD_ZONE;
        end else if (i_cfg_valid) begin
            unique case (rcfd_pkg::t_cfg_reg'(i_cfg_index))
                rcfd_pkg::CFG_CHANNEL_MIN:    r_cfg.channel_min    <= i_cfg_data;
                rcfd_pkg::CFG_CHANNEL_MAX:    r_cfg.channel_max    <= i_cfg_data;
                rcfd_pkg::CFG_CHANNEL_CENTER: r_cfg.channel_center <= i_cfg_data;
                rcfd_pkg::CFG_DEAD_ZONE:      r_cfg.dead_zone      <= i_cfg_data[rcfd_pkg::DZ_W-1:0];
                default:                      r_cfg                <= r_cfg;
            endcase
        end
    end

    rcfd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_rx_byte    (i_rx_byte),
        .i_frame_start(i_frame_start),
        .o_push       (w_push),
        .o_push_frame (w_push_frame)
    );

    rcfd_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_frame(w_push_frame),
        .i_pop       (w_pop),
        .o_head      (w_head),
        .o_status    (w_q_status)
    );

    rcfd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_head          (w_head),
        .i_q_status      (w_q_status),
        .o_pop           (w_pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_stick         (w_stick),
        .o_wheel         (o_wheel_channel),
        .o_switch_pair   (o_switch_pair),
        .o_mouse         (w_mouse),
        .o_mouse_buttons (o_mouse_buttons),
        .o_key_mask      (o_key_mask),
        .o_frame_accepted(o_frame_accepted)
    );

    assign o_stick_right_x = w_stick[0];
    assign o_stick_right_y = w_stick[1];
    assign o_stick_left_x  = w_stick[2];
    assign o_stick_left_y  = w_stick[3];
    assign o_mouse_x       = w_mouse[0];
    assign o_mouse_y       = w_mouse[1];
    assign o_mouse_z       = w_mouse[2];

    // A completed frame never arrives at a full queue.
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_status.full)
        else $error("frame pushed into a full queue");

    // The decode stage only takes a frame that is present.
    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_status.empty)
        else $error("frame popped from an empty queue");

    // A new result always comes from a frame taken off the queue.
    a_result_from_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_pop))
        else $error("result raised without a decoded frame");

endmodule

>>> rtl/rcfd_front.sv
// ----------------------------------------------------------------------------
// rcfd_front
// Byte assembly: tracks the byte position and hands complete frames on.
// ----------------------------------------------------------------------------
module rcfd_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_accept,
    input  logic [7:0]              i_rx_byte,
    input  logic                    i_frame_start,
    output logic                    o_push,
    output rcfd_pkg::t_frame        o_push_frame
);

    logic [rcfd_pkg::POS_W-1:0] r_pos;
    logic [rcfd_pkg::POS_W-1:0] n_pos;
    logic [rcfd_pkg::POS_W-1:0] w_pos_eff;
    logic [7:0]                 r_buf [rcfd_pkg::BUF_BYTES];

    assign w_pos_eff = i_frame_start ? '0 : r_pos;

    always_comb begin
        n_pos  = r_pos;
        o_push = 1'b0;
        if (i_accept) begin
            priority if (w_pos_eff == rcfd_pkg::POS_W'(rcfd_pkg::FRAME_BYTES)) begin
                n_pos = w_pos_eff;
            end else if (w_pos_eff == rcfd_pkg::POS_W'(rcfd_pkg::BUF_BYTES)) begin
                n_pos  = rcfd_pkg::POS_W'(rcfd_pkg::FRAME_BYTES);
                o_push = 1'b1;
            end else begin
                n_pos = w_pos_eff + 1'b1;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < rcfd_pkg::BUF_BYTES; i++) begin
            o_push_frame[i] = r_buf[i];
        end
        // The final byte goes straight into the frame without being buffered.
        o_push_frame[rcfd_pkg::BUF_BYTES] = i_rx_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && (w_pos_eff < rcfd_pkg::POS_W'(rcfd_pkg::BUF_BYTES))) begin
            r_buf[w_pos_eff] <= i_rx_byte;
        end
    end

endmodule

>>> rtl/rcfd_queue.sv
// ----------------------------------------------------------------------------
// rcfd_queue
// Short frame queue between the assembly front and the decode back.
// ----------------------------------------------------------------------------
module rcfd_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  rcfd_pkg::t_frame       i_push_frame,
    input  logic                   i_pop,
    output rcfd_pkg::t_frame       o_head,
    output rcfd_pkg::t_q_status    o_status
);

    localparam int PTR_W = (rcfd_pkg::QUEUE_DEPTH > 1) ? $clog2(rcfd_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(rcfd_pkg::QUEUE_DEPTH + 1);

    rcfd_pkg::t_frame  r_mem [rcfd_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(rcfd_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_status.full  = (r_count == CNT_W'(rcfd_pkg::QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_head         = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_frame;
        end
    end

endmodule

>>> rtl/rcfd_back.sv
// ----------------------------------------------------------------------------
// rcfd_back
// Frame decode: unpacks channels, range checks and updates the held values.
// ----------------------------------------------------------------------------
module rcfd_back (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  rcfd_pkg::t_cfg                        i_cfg,
    input  rcfd_pkg::t_frame                      i_head,
    input  rcfd_pkg::t_q_status                   i_q_status,
    output logic                                  o_pop,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [rcfd_pkg::STICK_W-1:0]   o_stick [4],
    output logic signed [rcfd_pkg::WORD_W-1:0]    o_wheel,
    output logic [rcfd_pkg::SW_W-1:0]             o_switch_pair,
    output logic signed [rcfd_pkg::WORD_W-1:0]    o_mouse [3],
    output logic [rcfd_pkg::WORD_W-1:0]           o_mouse_buttons,
    output logic [rcfd_pkg::WORD_W-1:0]           o_key_mask,
    output logic                                  o_frame_accepted
);

    logic [rcfd_pkg::CH_W-1:0]   w_ch [4];
    logic                        w_ok;
    logic                        r_out_valid;
    logic                        r_ok;
    logic signed [rcfd_pkg::STICK_W-1:0] r_stick [4];
    logic [rcfd_pkg::WORD_W-1:0] r_wheel;
    logic [rcfd_pkg::SW_W-1:0]   r_switch;
    logic [rcfd_pkg::WORD_W-1:0] r_mouse [3];
    logic [rcfd_pkg::WORD_W-1:0] r_buttons;
    logic [rcfd_pkg::WORD_W-1:0] r_keys;

    // The output register is free when empty or being taken this cycle.
    assign o_pop = !i_q_status.empty && (!r_out_valid || i_out_ready);

    assign w_ch[0] = {i_head[1][2:0], i_head[0]};
    assign w_ch[1] = {i_head[2][5:0], i_head[1][7:3]};
    assign w_ch[2] = {i_head[4][0], i_head[3], i_head[2][7:6]};
    assign w_ch[3] = {i_head[5][3:0], i_head[4][7:1]};

    always_comb begin
        w_ok = 1'b1;
        for (int i = 0; i < 4; i++) begin
            if ((w_ch[i] < i_cfg.channel_min) || (w_ch[i] > i_cfg.channel_max)) begin
                w_ok = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_ok        <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                r_stick[i] <= '0;
            end
            for (int i = 0; i < 3; i++) begin
                r_mouse[i] <= '0;
            end
            r_wheel   <= '0;
            r_switch  <= '0;
            r_buttons <= '0;
            r_keys    <= '0;
        end else begin
            if (o_pop) begin
                r_out_valid <= 1'b1;
                r_ok        <= w_ok;
                if (w_ok) begin
                    for (int i = 0; i < 4; i++) begin
                        r_stick[i] <= rcfd_pkg::center_stick(w_ch[i], i_cfg.channel_center,
                                                             i_cfg.dead_zone);
                    end
                    r_switch   <= i_head[5][7:4];
                    r_mouse[0] <= {i_head[7], i_head[6]};
                    r_mouse[1] <= {i_head[9], i_head[8]};
                    r_mouse[2] <= {i_head[11], i_head[10]};
                    r_buttons  <= {i_head[13], i_head[12]};
                    r_keys     <= {i_head[15], i_head[14]};
                    r_wheel    <= {i_head[17], i_head[16]}
                                  - {5'b00000, i_cfg.channel_center};
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_frame_accepted = r_ok;
    assign o_stick          = r_stick;
    assign o_wheel          = $signed(r_wheel);
    assign o_switch_pair    = r_switch;
    assign o_mouse[0]       = $signed(r_mouse[0]);
    assign o_mouse[1]       = $signed(r_mouse[1]);
    assign o_mouse[2]       = $signed(r_mouse[2]);
    assign o_mouse_buttons  = r_buttons;
    assign o_key_mask       = r_keys;

endmodule
